// ===== design/forward_box_blur_3x3_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 box blur
// Shorthands for concurrent checks clocked on clk with arst_n as disable.
// ----------------------------------------------------------------------------
`ifndef FORWARD_BOX_BLUR_3X3_TOP_ASSERT_SVH
`define FORWARD_BOX_BLUR_3X3_TOP_ASSERT_SVH

// invariant checked on every edge
`define BBX_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define BBX_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BBX_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/bbx_pkg.sv =====
// ----------------------------------------------------------------------------
// bbx_pkg
// Shared types, constants and the reciprocal table of the 3x3 box blur.
// ----------------------------------------------------------------------------
package bbx_pkg;

	localparam int MAX_SIZE_DEF   = 1024;
	localparam int FRAME_SIZE_RST = 1024;
	localparam int JOBQ_DEPTH     = 4;
	localparam int OUTQ_DEPTH     = 4;

	// quotient = (sum * recip) >> RECIP_SHIFT, exact for sums below 2**21
	localparam int          RECIP_SHIFT = 24;
	localparam logic [24:0] RECIP_DIV1  = 25'd16777216;
	localparam logic [24:0] RECIP_DIV2  = 25'd8388608;
	localparam logic [24:0] RECIP_DIV3  = 25'd5592406;
	localparam logic [24:0] RECIP_DIV4  = 25'd4194304;
	localparam logic [24:0] RECIP_DIV6  = 25'd2796203;
	localparam logic [24:0] RECIP_DIV9  = 25'd1864136;

	// channel 0 red, 1 green, 2 blue
	typedef logic [2:0][15:0] pix_t;

	// one complete window: grid[row][col]
	typedef struct packed {
		pix_t [2:0][2:0] grid;
		logic [9:0]      base_row;
		logic [9:0]      base_col;
		logic            last_row;
		logic            last_col;
	} job_t;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [9:0]  row;
		logic [9:0]  col;
		logic        run_end;
	} res_t;

	// reciprocal for the divisor (3-a)*(3-b)
	function automatic logic [24:0] recip(input logic [1:0] a, input logic [1:0] b);
		logic [3:0] d;
		d = {2'b00, 2'd3 - a} * {2'b00, 2'd3 - b};
		unique case (d)
			4'd9:    recip = RECIP_DIV9;
			4'd6:    recip = RECIP_DIV6;
			4'd4:    recip = RECIP_DIV4;
			4'd3:    recip = RECIP_DIV3;
			4'd2:    recip = RECIP_DIV2;
			default: recip = RECIP_DIV1;
		endcase
	endfunction

endpackage

// ===== design/bbx_fifo.sv =====
// ----------------------------------------------------------------------------
// bbx_fifo
// Small flop-based queue, push when not full, pop when not empty.
// ----------------------------------------------------------------------------
module bbx_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (AW+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (AW+1)'(1);
			end
		end
	end

endmodule

// ===== design/bbx_front.sv =====
// ----------------------------------------------------------------------------
// bbx_front
// Pixel intake: raster counters, line stores, window registers; emits jobs.
// ----------------------------------------------------------------------------
`include "forward_box_blur_3x3_top_assert.svh"

module bbx_front #(
	parameter int MAX_SIZE = bbx_pkg::MAX_SIZE_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  bbx_pkg::pix_t  px,
	input  logic           cfg_we,
	input  logic [10:0]    cfg_size,
	output bbx_pkg::job_t  job,
	output logic           job_push,
	input  logic           job_full
);

	localparam int CW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int SW = $clog2(MAX_SIZE + 1);
	localparam int TW = (CW > 10) ? CW : 10;

	logic [10:0]   frame_size_q;
	logic [SW-1:0] n_eff;
	logic [CW-1:0] row_q, col_q;
	logic          last_row, last_col, accept;

	logic          v_s1, lrow_s1, lcol_s1;
	logic [CW-1:0] row_s1, col_s1;
	bbx_pkg::pix_t px_s1;
	logic          need_s1, adv_s1;

	bbx_pkg::pix_t old_rd_q, new_rd_q;
	bbx_pkg::pix_t older_mem [MAX_SIZE];
	bbx_pkg::pix_t newer_mem [MAX_SIZE];

	bbx_pkg::pix_t [1:0][2:0] win_q;
	bbx_pkg::pix_t [2:0]      colv;

	always_comb begin
		if (int'(frame_size_q) < 3) begin
			n_eff = SW'(3);
		end else if (int'(frame_size_q) > MAX_SIZE) begin
			n_eff = SW'(MAX_SIZE);
		end else begin
			n_eff = SW'(frame_size_q);
		end
	end

	assign last_row = (SW'(row_q) == n_eff - SW'(1));
	assign last_col = (SW'(col_q) == n_eff - SW'(1));

	assign need_s1 = (int'(row_s1) >= 2) && (int'(col_s1) >= 2);
	assign adv_s1  = v_s1 && (!need_s1 || !job_full);
	assign full    = v_s1 && !adv_s1;
	assign accept  = push && !full;

	// raster position and frame size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_size_q <= 11'(bbx_pkg::FRAME_SIZE_RST);
			row_q        <= '0;
			col_q        <= '0;
		end else if (cfg_we) begin
			frame_size_q <= cfg_size;
			row_q        <= '0;
			col_q        <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + CW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1    <= px;
			row_s1   <= row_q;
			col_s1   <= col_q;
			lrow_s1  <= last_row;
			lcol_s1  <= last_col;
			old_rd_q <= older_mem[col_q];
			new_rd_q <= newer_mem[col_q];
		end
	end

	// line stores: write back the column once the pixel leaves s1
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			older_mem[col_s1] <= new_rd_q;
			newer_mem[col_s1] <= px_s1;
		end
	end

	assign colv[0] = old_rd_q;
	assign colv[1] = new_rd_q;
	assign colv[2] = px_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (adv_s1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= colv;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			job.grid[i][0] = win_q[0][i];
			job.grid[i][1] = win_q[1][i];
			job.grid[i][2] = colv[i];
		end
		job.base_row = 10'(TW'(row_s1) - TW'(2));
		job.base_col = 10'(TW'(col_s1) - TW'(2));
		job.last_row = lrow_s1;
		job.last_col = lcol_s1;
	end

	assign job_push = adv_s1 && need_s1;

	`BBX_ASSERT(a_col_range, SW'(col_q) < n_eff, "column counter beyond frame")
	`BBX_ASSERT_NEXT(a_s1_hold, v_s1 && !adv_s1, v_s1 && $stable(col_s1) && $stable(px_s1), "s1 lost under stall")
	`BBX_ASSERT_NEXT(a_col_step, accept && !cfg_we && !last_col, col_q == $past(col_q) + CW'(1), "column did not advance")

endmodule

// ===== design/bbx_back.sv =====
// ----------------------------------------------------------------------------
// bbx_back
// Result sequencer: walks the clipped sub-windows of a job, sums, divides.
// ----------------------------------------------------------------------------
`include "forward_box_blur_3x3_top_assert.svh"

module bbx_back (
	input  logic          clk,
	input  logic          arst_n,
	input  bbx_pkg::job_t job,
	input  logic          job_valid,
	output logic          job_pop,
	output bbx_pkg::res_t res,
	output logic          res_valid,
	input  logic          res_ready
);

	logic [1:0] a_cnt_q, b_cnt_q, a_hi, b_hi;
	logic       en, fire, last;

	logic [2:0][2:0][17:0] rs;
	logic [2:0][2:0][17:0] rs_s1;
	logic [1:0]            a_s1, b_s1;
	logic [9:0]            row_s1, col_s1;
	logic                  end_s1, v_s1;

	logic [2:0][19:0] sum;
	logic [2:0][19:0] sum_s2;
	logic [1:0]       a_s2, b_s2;
	logic [9:0]       row_s2, col_s2;
	logic             end_s2, v_s2;

	logic [24:0]      rcp;
	logic [2:0][44:0] prod;
	logic             v_s3;
	bbx_pkg::res_t    res_s3;

	assign en   = !v_s3 || res_ready;
	assign a_hi = job.last_row ? 2'd2 : 2'd0;
	assign b_hi = job.last_col ? 2'd2 : 2'd0;
	assign fire = job_valid && en;
	assign last = (a_cnt_q == a_hi) && (b_cnt_q == b_hi);
	assign job_pop = fire && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_cnt_q <= '0;
			b_cnt_q <= '0;
		end else if (fire) begin
			if (last) begin
				a_cnt_q <= '0;
				b_cnt_q <= '0;
			end else if (b_cnt_q == b_hi) begin
				b_cnt_q <= '0;
				a_cnt_q <= a_cnt_q + 2'd1;
			end else begin
				b_cnt_q <= b_cnt_q + 2'd1;
			end
		end
	end

	// row sums over columns b..2
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				rs[i][k] = '0;
				for (int j = 0; j < 3; j++) begin
					if (j >= int'(b_cnt_q)) begin
						rs[i][k] = rs[i][k] + 18'(job.grid[i][j][k]);
					end
				end
			end
		end
	end

	// window sums over rows a..2
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum[k] = '0;
			for (int i = 0; i < 3; i++) begin
				if (i >= int'(a_s1)) begin
					sum[k] = sum[k] + 20'(rs_s1[i][k]);
				end
			end
		end
	end

	assign rcp = bbx_pkg::recip(a_s2, b_s2);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod[k] = 45'(sum_s2[k]) * 45'(rcp);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rs_s1  <= rs;
			a_s1   <= a_cnt_q;
			b_s1   <= b_cnt_q;
			row_s1 <= job.base_row + {8'b0, a_cnt_q};
			col_s1 <= job.base_col + {8'b0, b_cnt_q};
			end_s1 <= last;

			sum_s2 <= sum;
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			row_s2 <= row_s1;
			col_s2 <= col_s1;
			end_s2 <= end_s1;

			res_s3.red     <= prod[0][bbx_pkg::RECIP_SHIFT +: 16];
			res_s3.green   <= prod[1][bbx_pkg::RECIP_SHIFT +: 16];
			res_s3.blue    <= prod[2][bbx_pkg::RECIP_SHIFT +: 16];
			res_s3.row     <= row_s2;
			res_s3.col     <= col_s2;
			res_s3.run_end <= end_s2;
		end
	end

	assign res       = res_s3;
	assign res_valid = v_s3;

	`BBX_ASSERT_NOW(a_mid_job, (a_cnt_q != 2'd0) || (b_cnt_q != 2'd0), job_valid, "sub-window count without job")
	`BBX_ASSERT_NEXT(a_pop_clear, job_pop, (a_cnt_q == 2'd0) && (b_cnt_q == 2'd0), "sequencer not cleared after job")
	`BBX_ASSERT_NEXT(a_out_hold, v_s3 && !res_ready, v_s3 && $stable(res_s3), "result dropped under stall")

endmodule

// ===== design/forward_box_blur_3x3_top.sv =====
// ----------------------------------------------------------------------------
// forward_box_blur_3x3_top
// Forward 3x3 mean filter over a square RGB frame streamed in raster order.
// ----------------------------------------------------------------------------
// Pixels enter one per cycle while full is low. The result at (row q, col p)
// is the per-channel mean of rows q..q+2 and columns p..p+2, clipped at the
// bottom and right frame edges and divided (truncating) by the pixel count
// left in the window. A result leaves as soon as the pixel that completes its
// window is in, tagged with its row and column; run_end marks the last result
// caused by one pixel. Pixels in the first two rows or columns cause no
// result, an interior pixel causes one, a last-column pixel three, a last-row
// pixel three and the final pixel of a frame nine. The back end makes one
// result per cycle while the result queue has room; the edge bursts are
// absorbed by a four-deep job queue and then push back through full.
// Writing frame_size (any value; below 3 acts as 3, above MAX_SIZE as
// MAX_SIZE) restarts the frame at row 0, column 0. cfg_ready is always high;
// write only while the block is drained. No clearing pass is needed after
// reset: the line stores are only read back once a frame has written them.
// ----------------------------------------------------------------------------
module forward_box_blur_3x3_top #(
	parameter int MAX_SIZE = bbx_pkg::MAX_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	// pixel input, a transfer when push && !full
	input  logic        push,
	output logic        full,
	input  logic [15:0] in_red,
	input  logic [15:0] in_green,
	input  logic [15:0] in_blue,

	// frame size write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] frame_size,

	// result output, a transfer when pop && !empty
	output logic        empty,
	input  logic        pop,
	output logic [15:0] out_red,
	output logic [15:0] out_green,
	output logic [15:0] out_blue,
	output logic [9:0]  out_row,
	output logic [9:0]  out_col,
	output logic        run_end
);

	bbx_pkg::pix_t px;
	bbx_pkg::job_t job_in, job_out;
	logic          job_push, job_full, job_empty, job_pop;
	bbx_pkg::res_t res, res_out;
	logic          res_valid, outq_full;

	assign px[0]     = in_red;
	assign px[1]     = in_green;
	assign px[2]     = in_blue;
	assign cfg_ready = 1'b1;

	// front: counters, line stores and the sliding 3x3 window
	bbx_front #(
		.MAX_SIZE (MAX_SIZE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.px       (px),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_size (frame_size),
		.job      (job_in),
		.job_push (job_push),
		.job_full (job_full)
	);

	// completed windows waiting for the back end
	bbx_fifo #(
		.W     ($bits(bbx_pkg::job_t)),
		.DEPTH (bbx_pkg::JOBQ_DEPTH)
	) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (job_out),
		.empty  (job_empty)
	);

	// back: one clipped sub-window mean per cycle while the result queue has room
	bbx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_out),
		.job_valid (!job_empty),
		.job_pop   (job_pop),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (!outq_full)
	);

	// result queue decouples the consumer from the back pipeline
	bbx_fifo #(
		.W     ($bits(bbx_pkg::res_t)),
		.DEPTH (bbx_pkg::OUTQ_DEPTH)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.wdata  (res),
		.full   (outq_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign out_red   = res_out.red;
	assign out_green = res_out.green;
	assign out_blue  = res_out.blue;
	assign out_row   = res_out.row;
	assign out_col   = res_out.col;
	assign run_end   = res_out.run_end;

endmodule
